// File: rtl/cbea_pkg.sv
// ============================================================================
// cbea_pkg - shared types and constants of the extent allocator
// Beat layouts of the request and response channels, field widths and
// operation codes.
// ============================================================================
package cbea_pkg;

    // field widths
    localparam int CNT_W       = 13;
    localparam int START_W     = 12;
    localparam int CNT_MAX_INT = (1 << CNT_W) - 1;

    // extent count register after reset
    localparam int                 EXT_RESET_INT = 4096;
    localparam logic [CNT_W-1:0]   EXT_RESET     = CNT_W'(EXT_RESET_INT);

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // request beat
    typedef struct packed {
        logic               operation;
        logic [CNT_W-1:0]   run_length;
        logic [START_W-1:0] free_start;
    } t_req;

    // response beat
    typedef struct packed {
        logic               success;
        logic [START_W-1:0] run_start;
        logic [CNT_W-1:0]   free_extents;
    } t_rsp;

endpackage

// File: rtl/contiguous_bitmap_extent_allocator.sv
// ============================================================================
// contiguous_bitmap_extent_allocator - first-fit contiguous extent allocator
// One bit per extent kept in a word-wide map memory, with a free extent
// count; allocate finds the first free run of a given length, free clears one.
// ============================================================================
// The map lives in a single-port-read memory of MAP_WORD_BITS-wide words and
// every request is served one word a cycle from that memory. An allocate reads
// words from extent 0 upward until the first fitting run completes (at most
// ceil(N / MAP_WORD_BITS) reads for N managed extents), then rewrites the words
// that the run covers, one a cycle. A free walks the words from extent 0 up to
// the word holding the last extent of the clipped run. Zero lengths, runs longer
// than N and frees that clip to nothing go straight to the response. One request
// is in work at a time; a finished response waits in the output register while
// the next request is taken. After reset and after each write of the extent count
// the map is cleared one word a cycle over ceil(min(MAP_EXTENTS, 8191) /
// MAP_WORD_BITS) words (64 with the defaults), during which requests are stalled.
// ============================================================================
module contiguous_bitmap_extent_allocator
    import cbea_pkg::*;
#(
    parameter int MAP_EXTENTS   = 4096,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output t_rsp             o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam int W         = MAP_WORD_BITS;
    localparam int N_CAP     = (MAP_EXTENTS > CNT_MAX_INT) ? CNT_MAX_INT : MAP_EXTENTS;
    localparam int N_RST     = (N_CAP < EXT_RESET_INT) ? N_CAP : EXT_RESET_INT;
    localparam int MEM_WORDS = (N_CAP + W - 1) / W;
    localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int XW        = CNT_W + 1;
    localparam int LW        = $clog2(W + 1);
    localparam int LG        = $clog2(W);
    localparam int P         = 2 ** LG;
    localparam int CW        = LG + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_raddr, r_daddr, r_run_addr;
    logic [XW-1:0]      r_rbase, r_dbase, r_run_base, r_lo, r_hi;
    logic [CNT_W-1:0]   r_n, r_fc, r_len, r_carry;
    logic               r_op, r_ok, r_rv, r_chg_v, r_out_valid;
    logic [START_W-1:0] r_start;
    logic [W-1:0]       r_rdata, r_chg;
    t_rsp               r_out;
    logic [W-1:0]       mem [MEM_WORDS];

    logic               acc, out_free, rd_en, wr_en;
    logic [AW-1:0]      wr_addr;
    logic [W-1:0]       wr_data, u_eff, found, rmw_mask;
    logic               found_any, in_word, last_scan, last_rmw;
    logic [CW-1:0]      found_idx, trail_cnt, pop_cnt;
    logic [XW-1:0]      n_x, len_x, idx_x, st, carry_sum, req_hi_raw, req_hi, req_lo;
    logic [CNT_W-1:0]   carry_full, fc_now, n_cfg;

    assign n_x   = XW'(r_n);
    assign len_x = XW'(r_len);

    // handshakes
    assign o_req_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;
    assign acc         = i_req_valid && !o_req_stall;
    assign out_free    = !r_out_valid || !i_rsp_stall;

    // map word with extents beyond the managed count shown as used
    always_comb begin
        logic [XW-1:0] pos;
        pos = '0;
        for (int i = 0; i < W; i++) begin
            pos      = r_dbase + XW'(i);
            u_eff[i] = r_rdata[i] | (pos >= n_x);
        end
    end

    // per bit: does a free run of the requested length end here
    always_comb begin
        logic [W-1:0]  thermo_len, win, pre;
        logic [LW-1:0] sh;
        logic [XW-1:0] reach;
        logic          f;
        thermo_len = ~({W{1'b1}} << r_len[LW-1:0]);
        win        = '0;
        pre        = '0;
        sh         = '0;
        reach      = '0;
        f          = 1'b0;
        for (int i = 0; i < W; i++) begin
            pre   = ~({W{1'b1}} << (i + 1));
            f     = (u_eff & pre) == '0;
            reach = XW'(r_carry) + XW'(i + 1);
            if (len_x <= XW'(i + 1)) begin
                // run lies wholly inside this word
                sh       = LW'(XW'(i + 1) - len_x);
                win      = thermo_len << sh;
                found[i] = (u_eff & win) == '0;
            end else begin
                // run continues from earlier words
                found[i] = f && (reach >= len_x);
            end
        end
    end

    // lowest bit at which a run completes
    always_comb begin
        logic [P-1:0] v;
        logic [CW-1:0] cnt;
        v   = P'(found);
        cnt = '0;
        for (int k = LG - 1; k >= 0; k--) begin
            if ((v & ~({P{1'b1}} << (1 << k))) == '0) begin
                cnt = cnt + CW'(1 << k);
                v   = v >> (1 << k);
            end
        end
        found_idx = cnt;
    end

    // free extents at the top of the word, carried into the next one
    always_comb begin
        logic [P-1:0] v;
        logic [CW-1:0] cnt;
        v   = P'(u_eff) << (P - W);
        cnt = '0;
        for (int k = LG - 1; k >= 0; k--) begin
            if ((v & ~({P{1'b1}} >> (1 << k))) == '0) begin
                cnt = cnt + CW'(1 << k);
                v   = v << (1 << k);
            end
        end
        trail_cnt = cnt;
    end

    // bit count of the last freed word, adder tree
    always_comb begin
        logic [CW-1:0] pc [P];
        logic [P-1:0]  chg;
        chg = P'(r_chg);
        for (int j = 0; j < P; j++) begin
            pc[j] = CW'(chg[j]);
        end
        for (int k = 0; k < LG; k++) begin
            for (int j = 0; j < P; j += 2 * (1 << k)) begin
                pc[j] = pc[j] + pc[j + (1 << k)];
            end
        end
        pop_cnt = pc[0];
    end

    // bits of the current word inside the run being marked or freed
    always_comb begin
        logic [XW-1:0] pos;
        pos = '0;
        for (int j = 0; j < W; j++) begin
            pos         = r_dbase + XW'(j);
            rmw_mask[j] = (pos >= r_lo) && (pos < r_hi);
        end
    end

    assign found_any  = |found;
    assign idx_x      = XW'(found_idx);
    assign st         = r_dbase + idx_x + XW'(1) - len_x;
    assign in_word    = len_x <= (idx_x + XW'(1));
    assign last_scan  = (r_dbase + XW'(W)) >= n_x;
    assign last_rmw   = (r_dbase + XW'(W)) >= r_hi;
    assign carry_sum  = XW'(r_carry) + XW'(W);
    assign carry_full = (carry_sum > XW'(CNT_MAX_INT)) ? CNT_W'(CNT_MAX_INT)
                                                       : carry_sum[CNT_W-1:0];
    assign fc_now     = r_fc + (r_chg_v ? CNT_W'(pop_cnt) : '0);
    assign n_cfg      = (i_cfg_data > CNT_W'(N_CAP)) ? CNT_W'(N_CAP) : i_cfg_data;

    // clipped free range of the incoming beat
    assign req_lo     = XW'(i_req.free_start);
    assign req_hi_raw = XW'(i_req.free_start) + XW'(i_req.run_length);
    assign req_hi     = (req_hi_raw > n_x) ? n_x : req_hi_raw;

    // memory port control
    always_comb begin
        rd_en = 1'b0;
        if (r_state == S_SCAN) begin
            rd_en = (r_rbase < n_x) && !(r_rv && (found_any || last_scan));
        end else if (r_state == S_RMW) begin
            rd_en = (r_rbase < r_hi) && !(r_rv && last_rmw);
        end
        wr_en   = (r_state == S_CLEAR) || ((r_state == S_RMW) && r_rv);
        wr_addr = (r_state == S_CLEAR) ? r_raddr : r_daddr;
        if (r_state == S_CLEAR) begin
            wr_data = '0;
        end else if (r_op == OP_ALLOC) begin
            wr_data = r_rdata | rmw_mask;
        end else begin
            wr_data = r_rdata & ~rmw_mask;
        end
    end

    // allocation map memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[r_raddr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_raddr     <= '0;
            r_n         <= CNT_W'(N_RST);
            r_rv        <= 1'b0;
            r_chg_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // new extent count restarts the block
            r_n         <= n_cfg;
            r_state     <= S_CLEAR;
            r_raddr     <= '0;
            r_rv        <= 1'b0;
            r_chg_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rv    <= rd_en;
            r_chg_v <= (r_state == S_RMW) && r_rv && (r_op == OP_FREE);
            if (rd_en) begin
                r_raddr <= r_raddr + AW'(1);
                r_rbase <= r_rbase + XW'(W);
                r_daddr <= r_raddr;
                r_dbase <= r_rbase;
            end
            if (r_chg_v) begin
                r_fc <= fc_now;
            end
            // response register: loaded when finished, emptied when taken
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_raddr <= r_raddr + AW'(1);
                    if (r_raddr == AW'(MEM_WORDS - 1)) begin
                        r_fc    <= r_n;
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (acc) begin
                        r_op    <= i_req.operation;
                        r_len   <= i_req.run_length;
                        r_start <= '0;
                        r_raddr <= '0;
                        r_rbase <= '0;
                        if (i_req.run_length == '0) begin
                            r_ok    <= 1'b0;
                            r_state <= S_FIN;
                        end else if (i_req.operation == OP_ALLOC) begin
                            r_carry    <= '0;
                            r_run_addr <= '0;
                            r_run_base <= '0;
                            if (i_req.run_length > r_n) begin
                                r_ok    <= 1'b0;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_ok <= 1'b1;
                            r_lo <= req_lo;
                            r_hi <= req_hi;
                            if (req_lo >= req_hi) begin
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_RMW;
                            end
                        end
                    end
                end

                S_SCAN: begin
                    if (r_rv) begin
                        if (found_any) begin
                            // run found: mark its words next
                            r_ok    <= 1'b1;
                            r_start <= st[START_W-1:0];
                            r_lo    <= st;
                            r_hi    <= st + len_x;
                            r_fc    <= (r_fc >= r_len) ? r_fc - r_len : '0;
                            if (in_word) begin
                                r_raddr <= r_daddr;
                                r_rbase <= r_dbase;
                            end else begin
                                r_raddr <= r_run_addr;
                                r_rbase <= r_run_base;
                            end
                            r_state <= S_RMW;
                        end else if (last_scan) begin
                            r_ok    <= 1'b0;
                            r_state <= S_FIN;
                        end else if (u_eff == '0) begin
                            // whole word free, run grows
                            r_carry <= carry_full;
                            if (r_carry == '0) begin
                                r_run_addr <= r_daddr;
                                r_run_base <= r_dbase;
                            end
                        end else begin
                            r_carry <= CNT_W'(trail_cnt);
                            if (trail_cnt != '0) begin
                                r_run_addr <= r_daddr;
                                r_run_base <= r_dbase;
                            end
                        end
                    end
                end

                S_RMW: begin
                    if (r_rv) begin
                        r_chg <= r_rdata & rmw_mask;
                        if (last_rmw) begin
                            r_state <= S_FIN;
                        end
                    end
                end

                S_FIN: begin
                    if (out_free) begin
                        r_out.success      <= r_ok;
                        r_out.run_start    <= r_start;
                        r_out.free_extents <= fc_now;
                        r_state            <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

// File: rtl/cbea_checker.sv
// ============================================================================
// cbea_checker - port-level checks of the extent allocator
// Tracks beats in flight and the managed extent count from the ports and
// checks held responses, beats in flight and the free count bound.
// ============================================================================
module cbea_checker
    import cbea_pkg::*;
#(
    parameter int MAP_EXTENTS = 4096
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             o_req_stall,
    input logic             o_rsp_valid,
    input logic             i_rsp_stall,
    input t_rsp             o_rsp,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [CNT_W-1:0] i_cfg_data
);

    localparam int N_CAP = (MAP_EXTENTS > CNT_MAX_INT) ? CNT_MAX_INT : MAP_EXTENTS;
    localparam int N_RST = (N_CAP < EXT_RESET_INT) ? N_CAP : EXT_RESET_INT;

    logic             acc_in, acc_out, cfg_wr;
    logic [2:0]       r_cnt;
    logic [CNT_W-1:0] r_n;

    assign acc_in  = i_req_valid && !o_req_stall;
    assign acc_out = o_rsp_valid && !i_rsp_stall;
    assign cfg_wr  = i_cfg_valid && o_cfg_ready;

    // beats accepted but not yet answered, and managed extent count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_n   <= CNT_W'(N_RST);
        end else if (cfg_wr) begin
            r_cnt <= '0;
            r_n   <= (i_cfg_data > CNT_W'(N_CAP)) ? CNT_W'(N_CAP) : i_cfg_data;
        end else begin
            r_cnt <= r_cnt + 3'(acc_in) - 3'(acc_out);
        end
    end

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall && !cfg_wr |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response dropped or changed");

    // at most one request in work and one response waiting
    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd2)
        else $error("too many requests in flight");

    // every response answers an accepted request
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> r_cnt != 3'd0)
        else $error("response without a request");

    // free count never exceeds the managed extents
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.free_extents <= r_n)
        else $error("free count above managed extents");

endmodule

bind contiguous_bitmap_extent_allocator cbea_checker #(
    .MAP_EXTENTS(MAP_EXTENTS)
) u_cbea_checker (.*);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench of the first-fit contiguous extent allocator
// Sends allocate and free requests and writes the extent count register.
// A predictor inside the bench keeps its own copy of the extent map and the
// free count, and every response beat is compared field by field with the
// oldest awaited response. The sender idles in bursts, the receiver stalls
// on its own pattern, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import cbea_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_EXTENTS    = 4096;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int IDLE_LIMIT     = 5000;
    localparam int TAIL_CYCLES    = 100;
    localparam int SHOWN_ERRORS   = 10;

    typedef struct {
        int first;
        int count;
    } t_run;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_req_valid = 1'b0;
    logic             o_req_stall;
    t_req             i_req       = '0;
    logic             o_rsp_valid;
    logic             i_rsp_stall = 1'b0;
    t_rsp             o_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data  = '0;

    // predictor state
    bit               extent_used [MAP_EXTENTS];
    int               free_total;
    logic [CNT_W-1:0] extent_reg;

    t_rsp awaited_rsp[$];
    t_run live_runs[$];
    int   fail_count      = 0;
    int   burst_left      = 0;
    bit   req_offered     = 1'b0;
    bit   rsp_holdoff_req = 1'b0;

    contiguous_bitmap_extent_allocator #(
        .MAP_EXTENTS   (MAP_EXTENTS),
        .MAP_WORD_BITS (64)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // managed extents: register value capped at the map size
    function automatic int map_span();
        return (int'(extent_reg) > MAP_EXTENTS) ? MAP_EXTENTS : int'(extent_reg);
    endfunction

    // map cleared and free count reloaded, as after reset or a register write
    function automatic void clear_extent_map();
        foreach (extent_used[i]) extent_used[i] = 1'b0;
        free_total = map_span();
        live_runs.delete();
    endfunction

    // applies one request to the predicted map and gives the response
    function automatic t_rsp apply_request(t_req r);
        t_rsp res;
        int   n;
        int   len;
        int   run;
        int   first;
        int   last;
        bit   found;
        res   = '0;
        n     = map_span();
        len   = int'(r.run_length);
        run   = 0;
        first = 0;
        found = 1'b0;
        if (len != 0) begin
            if (r.operation == OP_ALLOC) begin
                // first fit scan upward from extent 0
                for (int i = 0; i < n && !found; i++) begin
                    if (!extent_used[i]) begin
                        if (run == 0) first = i;
                        run++;
                        if (run == len) found = 1'b1;
                    end else begin
                        run = 0;
                    end
                end
                if (found) begin
                    for (int i = first; i < first + len; i++) extent_used[i] = 1'b1;
                    free_total    = (free_total >= len) ? free_total - len : 0;
                    res.success   = 1'b1;
                    res.run_start = START_W'(first);
                end
            end else begin
                // free clipped to the managed extents, only used bits counted
                last = int'(r.free_start) + len;
                if (last > n) last = n;
                for (int i = int'(r.free_start); i < last; i++) begin
                    if (extent_used[i]) begin
                        extent_used[i] = 1'b0;
                        free_total++;
                    end
                end
                res.success = 1'b1;
            end
        end
        res.free_extents = CNT_W'(free_total);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // one request beat, held until accepted, then a gap at the end of a burst
    task automatic send_request(input t_req r, output t_rsp predicted);
        i_req       <= r;
        i_req_valid <= 1'b1;
        req_offered  = 1'b1;
        do @(posedge i_clk); while (o_req_stall);
        predicted = apply_request(r);
        awaited_rsp.push_back(predicted);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_req_valid <= 1'b0;
            req_offered  = 1'b0;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(20, 40)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic issue(input logic op, input int len, input int first,
                         output t_rsp predicted);
        t_req r;
        r.operation  = op;
        r.run_length = CNT_W'(len);
        r.free_start = START_W'(first);
        send_request(r, predicted);
    endtask

    // sender stops and waits for every awaited response
    task automatic settle();
        if (req_offered) begin
            i_req_valid <= 1'b0;
            req_offered  = 1'b0;
        end
        while (awaited_rsp.size() != 0) @(posedge i_clk);
    endtask

    // extent count write, only with the block idle
    task automatic write_extent_count(input logic [CNT_W-1:0] value);
        settle();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        extent_reg   = value;
        clear_extent_map();
    endtask

    // ------------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------------

    function automatic void note_failure(string what, t_rsp want, t_rsp got);
        if (fail_count < SHOWN_ERRORS) begin
            $display("%0t %s: expected success %0d start %0d free %0d, got %0d %0d %0d",
                     $realtime, what, want.success, want.run_start, want.free_extents,
                     got.success, got.run_start, got.free_extents);
        end
        fail_count++;
    endfunction

    // every accepted response beat against the oldest awaited one
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
                note_failure("unexpected response", '0, o_rsp);
            end else begin
                want = awaited_rsp.pop_front();
                if (o_rsp.success !== want.success || o_rsp.run_start !== want.run_start ||
                    o_rsp.free_extents !== want.free_extents) begin
                    note_failure("response mismatch", want, o_rsp);
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin : rsp_stall_gen
        int mode;
        int mode_left;
        int phase;
        int period;
        int duty;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        period    = 4;
        duty      = 1;
        forever begin
            @(posedge i_clk);
            if (rsp_holdoff_req) begin
                rsp_holdoff_req = 1'b0;
                i_rsp_stall    <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
                period    = $urandom_range(2, 9);
                duty      = $urandom_range(1, period - 1);
            end
            mode_left--;
            phase = (phase + 1) % period;
            case (mode)
                0:       i_rsp_stall <= 1'b0;
                1:       i_rsp_stall <= ($urandom_range(0, 3) == 0);
                2:       i_rsp_stall <= ($urandom_range(0, 3) != 0);
                default: i_rsp_stall <= (phase < duty);
            endcase
        end
    end

    // watchdog on cycles with no beat accepted anywhere
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // zero length allocate and free are refused
    task automatic test_zero_length();
        t_rsp p;
        issue(OP_ALLOC, 0, 0, p);
        issue(OP_FREE, 0, 0, p);
    endtask

    // extremes of length and start on the full map
    task automatic test_field_extremes();
        t_rsp p;
        issue(OP_ALLOC, 1, 0, p);
        issue(OP_ALLOC, MAP_EXTENTS, 0, p);
        issue(OP_ALLOC, CNT_MAX_INT, 4095, p);
        issue(OP_FREE, 1, 0, p);
        issue(OP_ALLOC, MAP_EXTENTS, 0, p);
        issue(OP_ALLOC, 1, 0, p);
        issue(OP_FREE, CNT_MAX_INT, 4095, p);
        issue(OP_FREE, 1, 4095, p);
        issue(OP_FREE, MAP_EXTENTS, 0, p);
    endtask

    // a freed hole reused by a run that fits and skipped by one that does not
    task automatic test_fragmentation();
        t_rsp p;
        issue(OP_ALLOC, 10, 0, p);
        issue(OP_ALLOC, 5, 0, p);
        issue(OP_ALLOC, 10, 0, p);
        issue(OP_FREE, 5, 10, p);
        issue(OP_ALLOC, 6, 0, p);
        issue(OP_ALLOC, 5, 0, p);
        issue(OP_FREE, CNT_MAX_INT, 0, p);
    endtask

    // small map: over-long runs and frees clipped at the end
    task automatic test_small_map();
        t_rsp p;
        write_extent_count(CNT_W'(37));
        issue(OP_ALLOC, 38, 0, p);
        issue(OP_ALLOC, 37, 0, p);
        issue(OP_FREE, 5, 40, p);
        issue(OP_FREE, 100, 30, p);
        issue(OP_ALLOC, 7, 0, p);
    endtask

    // no managed extents at all
    task automatic test_empty_map();
        t_rsp p;
        write_extent_count('0);
        issue(OP_ALLOC, 1, 0, p);
        issue(OP_FREE, 1, 0, p);
    endtask

    // register above the map size is capped
    task automatic test_oversized_register();
        t_rsp p;
        write_extent_count(CNT_W'(CNT_MAX_INT));
        issue(OP_ALLOC, MAP_EXTENTS, 0, p);
        issue(OP_FREE, MAP_EXTENTS, 0, p);
    endtask

    // receiver holds off while the sender keeps offering, then sender waits
    task automatic test_stall_pressure();
        t_rsp p;
        write_extent_count(CNT_W'(MAP_EXTENTS));
        rsp_holdoff_req = 1'b1;
        burst_left      = 40;
        for (int k = 0; k < 40; k++) begin
            issue(($urandom_range(0, 3) == 0) ? OP_FREE : OP_ALLOC,
                  $urandom_range(1, 80), $urandom_range(0, 4095), p);
        end
        settle();
    endtask

    // one setting of the register, then mostly well-formed allocate and free
    task automatic run_random_phase(input int reg_value, input int items);
        t_rsp p;
        int   n;
        int   idx;
        int   len;
        int   first;
        int   pick;
        int   small_max;
        write_extent_count(CNT_W'(reg_value));
        n         = map_span();
        small_max = (n >= 512) ? 300 : ((n / 4 > 1) ? n / 4 : 1);
        for (int k = 0; k < items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 && live_runs.size() != 0) begin
                // free a run handed out earlier, sometimes only part of it
                idx   = $urandom_range(0, live_runs.size() - 1);
                first = live_runs[idx].first;
                len   = live_runs[idx].count;
                if ($urandom_range(0, 3) == 0) begin
                    first = first + $urandom_range(0, len - 1);
                    len   = $urandom_range(1, live_runs[idx].first + live_runs[idx].count
                                              - first);
                end
                live_runs.delete(idx);
                issue(OP_FREE, len, first, p);
            end else if (pick < 90) begin
                case ($urandom_range(0, 19))
                    0:       len = 0;
                    1:       len = $urandom_range(0, CNT_MAX_INT);
                    2, 3:    len = $urandom_range(1, n + 1);
                    default: len = $urandom_range(1, small_max);
                endcase
                issue(OP_ALLOC, len, $urandom_range(0, 4095), p);
                if (p.success) live_runs.push_back('{int'(p.run_start), len});
            end else begin
                // stray frees anywhere, any length
                len = ($urandom_range(0, 1) == 1) ? $urandom_range(0, CNT_MAX_INT)
                                                  : $urandom_range(0, 64);
                issue(OP_FREE, len, $urandom_range(0, 4095), p);
            end
        end
    endtask

    task automatic test_random_traffic();
        int spans[8];
        spans = '{1, 64, 65, 500, MAP_EXTENTS, CNT_MAX_INT, 0, MAP_EXTENTS};
        spans[6] = $urandom_range(2, MAP_EXTENTS);
        foreach (spans[i]) run_random_phase(spans[i], 125);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        extent_reg = EXT_RESET;
        clear_extent_map();
        burst_left = $urandom_range(1, 12);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_length();
        test_field_extremes();
        test_fragmentation();
        test_small_map();
        test_empty_map();
        test_oversized_register();
        test_stall_pressure();
        test_random_traffic();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && awaited_rsp.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/cbea_pkg.sv
rtl/contiguous_bitmap_extent_allocator.sv
rtl/cbea_checker.sv
verif/tb.sv
